[rtl/mmhnt_pkg.sv]
// shared constants and types for the highest-note tracker
package mmhnt_pkg;

  // number of note slots tracked, notes at or above this are ignored
  localparam int NOTE_SLOTS = 128;
  localparam logic [7:0] NOTE_LIMIT = 8'(NOTE_SLOTS);

  // saturation limit of the held counter
  localparam logic [7:0] HELD_MAX = 8'd128;

  // message types taken from the status high nibble
  localparam logic [3:0] MSG_NONE     = 4'h0;
  localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON  = 4'h9;

  // voice event codes
  localparam logic [1:0] EV_ATTACK   = 2'd0;
  localparam logic [1:0] EV_RETRIG   = 2'd1;
  localparam logic [1:0] EV_FALLBACK = 2'd2;
  localparam logic [1:0] EV_RELEASE  = 2'd3;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_SEARCH = 2'b10
  } state_t;

endpackage

[rtl/midi_mono_highest_note_tracker.sv]
// monophonic midi note tracker with highest-note priority
//
// usage: raw midi bytes enter one beat at a time on the in_ channel
// (in_valid / in_stall). status bytes are taken only when their low nibble
// matches the listen channel, which the user must write through the cfg_
// port only while idle; the block itself does not enforce this. note-on
// and note-off messages are assembled from two data bytes and a held flag
// is kept for each of the 128 notes. the voice plays the highest held
// note; each message that changes the voice gives one result beat on the
// out_ channel (out_valid / out_stall).
// attack, retrigger and release results leave the output register in the
// cycle after the completing byte. releasing the top note while others are
// held starts a downward search through the held flags, one slot a cycle on
// a shared decrement and test; in_stall stays high during the search.
// throughput: one byte a cycle outside the search while no result waits
// under out_stall; no new byte is taken until the search has ended.
// reset clears the message assembly, all held flags, the count, the played
// note and sets the listen channel to 0. while a result waits under
// out_stall, the input is stalled too, so no result is ever dropped.
module midi_mono_highest_note_tracker (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_midi_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_voice_event,
  output logic [6:0] out_play_note,
  output logic [6:0] out_velocity,
  output logic [7:0] out_held_count,
  // configuration write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_listen_channel
);
  import mmhnt_pkg::*;

  state_t       state_r, state_nxt;
  logic [3:0]   chan_r, chan_nxt;
  logic [3:0]   type_r, type_nxt;
  logic [6:0]   first_r, first_nxt;
  logic         have_first_r, have_first_nxt;
  logic [127:0] held_r, held_nxt;
  logic [7:0]   total_r, total_nxt;
  logic [6:0]   cur_r, cur_nxt;
  logic [6:0]   x_r, x_nxt;   // search pointer

  logic         out_valid_r, out_valid_nxt;
  logic [1:0]   ev_r, ev_nxt;
  logic [6:0]   note_r, note_nxt;
  logic [6:0]   vel_r, vel_nxt;
  logic [7:0]   cnt_r, cnt_nxt;

  logic         in_fire, out_fire;
  logic [6:0]   note;
  logic         in_range;
  logic [7:0]   total_dec;

  // input waits during the search and while a result is held back
  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;
  assign cfg_ready = 1'b1;

  assign note      = first_r;
  assign in_range  = {1'b0, note} < NOTE_LIMIT;
  assign total_dec = (total_r != 8'd0) ? (total_r - 8'd1) : 8'd0;

  always_comb begin
    state_nxt      = state_r;
    chan_nxt       = chan_r;
    type_nxt       = type_r;
    first_nxt      = first_r;
    have_first_nxt = have_first_r;
    held_nxt       = held_r;
    total_nxt      = total_r;
    cur_nxt        = cur_r;
    x_nxt          = x_r;
    out_valid_nxt  = out_fire ? 1'b0 : out_valid_r;
    ev_nxt         = ev_r;
    note_nxt       = note_r;
    vel_nxt        = vel_r;
    cnt_nxt        = cnt_r;

    if (cfg_valid && cfg_ready) begin
      chan_nxt = cfg_listen_channel;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_midi_byte[7]) begin
            // status: only the type changes
            if (in_midi_byte[3:0] == chan_r) begin
              type_nxt = in_midi_byte[7:4];
            end
          end else if (type_r != MSG_NOTE_ON && type_r != MSG_NOTE_OFF) begin
            type_nxt = MSG_NONE;
          end else if (!have_first_r) begin
            first_nxt      = in_midi_byte[6:0];
            have_first_nxt = 1'b1;
          end else begin
            // second data byte completes the message
            type_nxt       = MSG_NONE;
            first_nxt      = 7'd0;
            have_first_nxt = 1'b0;
            if (type_r == MSG_NOTE_ON) begin
              if (in_midi_byte[6:0] != 7'd0 && in_range && !held_r[note]) begin
                held_nxt[note] = 1'b1;
                total_nxt      = (total_r < HELD_MAX) ? (total_r + 8'd1) : total_r;
                cur_nxt        = (note >= cur_r) ? note : cur_r;
                out_valid_nxt  = 1'b1;
                ev_nxt         = (total_r == 8'd0) ? EV_ATTACK : EV_RETRIG;
                note_nxt       = cur_nxt;
                vel_nxt        = in_midi_byte[6:0];
                cnt_nxt        = total_nxt;
              end
            end else begin
              if (in_range && held_r[note]) begin
                held_nxt[note] = 1'b0;
                total_nxt      = total_dec;
                if (total_dec == 8'd0) begin
                  // last note gone
                  cur_nxt       = 7'd0;
                  held_nxt      = '0;
                  out_valid_nxt = 1'b1;
                  ev_nxt        = EV_RELEASE;
                  note_nxt      = 7'd0;
                  vel_nxt       = 7'd0;
                  cnt_nxt       = 8'd0;
                end else if (note == cur_r) begin
                  // top note released, look downward
                  x_nxt     = note;
                  state_nxt = S_SEARCH;
                end
              end
            end
          end
        end
      end
      S_SEARCH: begin
        if (x_r == 7'd0 || held_r[x_r]) begin
          cur_nxt       = x_r;
          out_valid_nxt = 1'b1;
          ev_nxt        = EV_FALLBACK;
          note_nxt      = x_r;
          vel_nxt       = 7'd0;
          cnt_nxt       = total_r;
          state_nxt     = S_IDLE;
        end else begin
          x_nxt = x_r - 7'd1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      chan_r       <= 4'd0;
      type_r       <= MSG_NONE;
      first_r      <= 7'd0;
      have_first_r <= 1'b0;
      held_r       <= '0;
      total_r      <= 8'd0;
      cur_r        <= 7'd0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      chan_r       <= chan_nxt;
      type_r       <= type_nxt;
      first_r      <= first_nxt;
      have_first_r <= have_first_nxt;
      held_r       <= held_nxt;
      total_r      <= total_nxt;
      cur_r        <= cur_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    ev_r   <= ev_nxt;
    note_r <= note_nxt;
    vel_r  <= vel_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_voice_event = ev_r;
  assign out_play_note   = note_r;
  assign out_velocity    = vel_r;
  assign out_held_count  = cnt_r;

  // the count always matches the held flags
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    total_r == 8'($countones(held_r)))
    else $error("held count differs from held flags");

  // no input is taken while searching
  a_search_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> in_stall)
    else $error("input not stalled during search");

  // a search only starts with the output register free
  a_search_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && state_nxt == S_SEARCH) |=> !out_valid_r)
    else $error("search started with a pending result");

  // a fallback always leaves notes held
  a_fallback_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ev_r == EV_FALLBACK) |-> (cnt_r != 8'd0))
    else $error("fallback reported with no note held");

endmodule
